// File: design/egb_pkg.sv
`timescale 1ns / 1ps
package egb_pkg;

  localparam int ArmW       = 6;
  localparam int EstW       = 24;
  localparam int CntW       = 16;
  localparam int RewardW    = 16;
  localparam int DrawW      = 16;
  localparam int StepW      = 16;
  localparam int CfgIdxW    = 2;
  localparam int CfgDataW   = 16;
  localparam int DefaultArms = 10;
  localparam int ArmCodes   = 1 << ArmW;

  localparam logic [CfgIdxW-1:0] CfgExploreThreshold = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgUpdateMode       = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgStepSize         = 2'd2;

  localparam logic [DrawW-1:0] ThresholdReset = 16'd6554;
  localparam logic [StepW-1:0] StepSizeReset  = 16'd6554;

  localparam logic ModeSampleAvg = 1'b0;
  localparam logic ModeConstStep = 1'b1;

  localparam logic KindFirst = 1'b0;

  typedef struct packed {
    logic                      kind;
    logic signed [RewardW-1:0] reward;
    logic [DrawW-1:0]          random_draw;
    logic [ArmW-1:0]           random_arm;
  } egb_in_t;

  typedef struct packed {
    logic [ArmW-1:0]        chosen_arm;
    logic                   explored;
    logic signed [EstW-1:0] updated_estimate;
  } egb_out_t;

  // Data passed along the row of arm cells
  typedef struct packed {
    logic                   best_vld;
    logic signed [EstW-1:0] best_est;
    logic [ArmW-1:0]        best_arm;
    logic signed [EstW-1:0] fetch_est;
    logic [CntW-1:0]        fetch_cnt;
  } egb_link_t;

  typedef struct packed {
    logic                   clear;
    logic                   wr_en;
    logic [ArmW-1:0]        wr_arm;
    logic signed [EstW-1:0] wr_est;
    logic [CntW-1:0]        wr_cnt;
    logic [ArmW-1:0]        sel_arm;
  } egb_cell_ctl_t;

  typedef struct packed {
    logic                      start;
    logic                      mode;
    logic [StepW-1:0]          step;
    logic signed [RewardW-1:0] reward;
    logic signed [EstW-1:0]    est;
    logic [CntW-1:0]           cnt;
  } egb_upd_req_t;

  typedef struct packed {
    logic                   done;
    logic signed [EstW-1:0] est;
    logic [CntW-1:0]        cnt;
  } egb_upd_rsp_t;

  typedef logic [ArmCodes-1:0][ArmW-1:0] arm_tab_t;

  // random_arm mod arms for every possible code, built at elaboration
  function automatic arm_tab_t arm_mod_table(int arms);
    arm_tab_t tab;
    int       r;
    r = 0;
    for (int i = 0; i < ArmCodes; i++) begin
      tab[i] = ArmW'(r);
      r = r + 1;
      if (r == arms) r = 0;
    end
    return tab;
  endfunction

endpackage

// File: design/egb_cell.sv
`timescale 1ns / 1ps
module egb_cell #(
  parameter int INDEX = 0
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  egb_pkg::egb_cell_ctl_t ctl_i,
  input  egb_pkg::egb_link_t    link_i,
  output egb_pkg::egb_link_t    link_o
);
  import egb_pkg::*;

  localparam logic [ArmW-1:0] MyArm = ArmW'(INDEX);

  logic signed [EstW-1:0] est_q;
  logic [CntW-1:0]        cnt_q;
  egb_link_t              link_d, link_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      est_q <= '0;
      cnt_q <= '0;
    end else if (ctl_i.clear) begin
      est_q <= '0;
      cnt_q <= '0;
    end else if (ctl_i.wr_en && ctl_i.wr_arm == MyArm) begin
      est_q <= ctl_i.wr_est;
      cnt_q <= ctl_i.wr_cnt;
    end
  end

  // strict compare keeps the lowest index on a tie
  always_comb begin
    link_d = link_i;
    if (!link_i.best_vld || est_q > link_i.best_est) begin
      link_d.best_vld = 1'b1;
      link_d.best_est = est_q;
      link_d.best_arm = MyArm;
    end
    if (ctl_i.sel_arm == MyArm) begin
      link_d.fetch_est = est_q;
      link_d.fetch_cnt = cnt_q;
    end
  end

  always_ff @(posedge clk_i) begin
    link_q <= link_d;
  end

  assign link_o = link_q;

endmodule

// File: design/egb_update.sv
`timescale 1ns / 1ps
module egb_update (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  egb_pkg::egb_upd_req_t req_i,
  output egb_pkg::egb_upd_rsp_t rsp_o
);
  import egb_pkg::*;

  localparam int DiffW   = EstW + 1;
  localparam int AdjW    = EstW + 2;
  localparam int ProdW   = DiffW + StepW + 1;
  localparam int BitCntW = $clog2(DiffW);

  localparam logic [2:0] U_IDLE = 3'd0;
  localparam logic [2:0] U_PREP = 3'd1;
  localparam logic [2:0] U_DIV  = 3'd2;
  localparam logic [2:0] U_MUL  = 3'd3;
  localparam logic [2:0] U_DADJ = 3'd4;
  localparam logic [2:0] U_SUM  = 3'd5;
  localparam logic [2:0] U_DONE = 3'd6;

  logic [2:0]              state_q;
  logic                    mode_q;
  logic [StepW-1:0]        step_q;
  logic signed [EstW-1:0]  est_q;
  logic [CntW-1:0]         cnt_q;
  logic signed [DiffW-1:0] diff_q;
  logic                    neg_q;
  logic [DiffW-1:0]        num_q;
  logic [CntW-1:0]         rem_q;
  logic [DiffW-1:0]        quot_q;
  logic [BitCntW-1:0]      bit_q;
  logic signed [ProdW-1:0] prod_q;
  logic signed [AdjW-1:0]  adj_q;
  logic signed [EstW-1:0]  res_q;

  logic [CntW:0]           rem_sh;
  logic                    rem_ge;
  logic [CntW:0]           rem_sub;
  logic signed [AdjW-1:0]  prod_hi;
  logic                    prod_rnd;
  logic signed [AdjW-1:0]  est_ext;

  assign rem_sh  = {rem_q, num_q[DiffW-1]};
  assign rem_ge  = rem_sh >= {1'b0, cnt_q};
  assign rem_sub = rem_sh - {1'b0, cnt_q};

  // toward-zero truncation: bump a negative product that has fraction bits
  assign prod_hi  = prod_q[ProdW-1:StepW];
  assign prod_rnd = prod_q[ProdW-1] && (|prod_q[StepW-1:0]);
  assign est_ext  = {{(AdjW-EstW){est_q[EstW-1]}}, est_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= U_IDLE;
    end else begin
      unique case (state_q)
        U_IDLE:  if (req_i.start) state_q <= U_PREP;
        U_PREP:  state_q <= (mode_q == ModeConstStep) ? U_MUL : U_DIV;
        U_DIV:   if (bit_q == '0) state_q <= U_DADJ;
        U_MUL:   state_q <= U_SUM;
        U_DADJ:  state_q <= U_SUM;
        U_SUM:   state_q <= U_DONE;
        U_DONE:  state_q <= U_IDLE;
        default: state_q <= U_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      U_IDLE: begin
        if (req_i.start) begin
          mode_q <= req_i.mode;
          step_q <= req_i.step;
          est_q  <= req_i.est;
          diff_q <= $signed({{(DiffW-RewardW){req_i.reward[RewardW-1]}}, req_i.reward})
                  - $signed({req_i.est[EstW-1], req_i.est});
          if (req_i.mode == ModeSampleAvg && req_i.cnt != '1) begin
            cnt_q <= req_i.cnt + CntW'(1);
          end else begin
            cnt_q <= req_i.cnt;
          end
        end
      end
      U_PREP: begin
        neg_q  <= diff_q[DiffW-1];
        num_q  <= diff_q[DiffW-1] ? DiffW'(-diff_q) : DiffW'(diff_q);
        rem_q  <= '0;
        quot_q <= '0;
        bit_q  <= BitCntW'(DiffW - 1);
        prod_q <= diff_q * $signed({1'b0, step_q});
      end
      U_DIV: begin
        num_q <= {num_q[DiffW-2:0], 1'b0};
        bit_q <= bit_q - BitCntW'(1);
        if (rem_ge) begin
          rem_q  <= rem_sub[CntW-1:0];
          quot_q <= {quot_q[DiffW-2:0], 1'b1};
        end else begin
          rem_q  <= rem_sh[CntW-1:0];
          quot_q <= {quot_q[DiffW-2:0], 1'b0};
        end
      end
      U_MUL: begin
        adj_q <= prod_hi + AdjW'(prod_rnd);
      end
      U_DADJ: begin
        adj_q <= neg_q ? -$signed({1'b0, quot_q}) : $signed({1'b0, quot_q});
      end
      U_SUM: begin
        res_q <= EstW'(est_ext + adj_q);
      end
      default: ;
    endcase
  end

  assign rsp_o.done = (state_q == U_DONE);
  assign rsp_o.est  = res_q;
  assign rsp_o.cnt  = cnt_q;

endmodule

// File: design/epsilon_greedy_bandit_agent.sv
`timescale 1ns / 1ps
// Channel  Direction  Signals                                      Carries
// in       input      in_valid_i / in_ready_o / in_data_i          one step request
// out      output     out_valid_o / out_ready_i / out_data_o       chosen arm, new estimate
// cfg      input      cfg_we_i / cfg_idx_i / cfg_wdata_i           register write, no wait
//
// First-step request: the accept, then the hand-off. Later step: the previous arm is fetched
// along the cell row, the update unit runs (its serial divider for sample average, a multiply
// for constant step), then an argmax runs along the row when exploiting, before the hand-off.
// One request is worked on at a time; the next is taken while the result waits in the output
// register, and the hand-off stalls while that register is full. Reset clears all arm state
// at once.
module epsilon_greedy_bandit_agent #(
  parameter int ARMS = egb_pkg::DefaultArms
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  egb_pkg::egb_in_t              in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output egb_pkg::egb_out_t             out_data_o,
  input  logic                          cfg_we_i,
  input  logic [egb_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [egb_pkg::CfgDataW-1:0]  cfg_wdata_i
);
  import egb_pkg::*;

  localparam int       ScanW  = $clog2(ARMS + 1);
  localparam arm_tab_t ModTab = arm_mod_table(ARMS);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_FETCH = 3'd1;
  localparam logic [2:0] S_UPD   = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [DrawW-1:0]          thr_q;
  logic                      mode_q;
  logic [StepW-1:0]          step_q;

  logic [2:0]                state_q;
  logic [ScanW-1:0]          scan_q;
  logic [ArmW-1:0]           last_arm_q;
  logic signed [RewardW-1:0] reward_q;
  logic [DrawW-1:0]          draw_q;
  logic [ArmW-1:0]           rarm_q;
  logic [ArmW-1:0]           res_arm_q;
  logic                      res_expl_q;
  logic signed [EstW-1:0]    res_est_q;
  logic                      out_valid_q;
  egb_out_t                  out_data_q;

  logic                      in_acc;
  logic                      out_free;
  egb_cell_ctl_t             cell_ctl;
  egb_link_t                 link [ARMS+1];
  egb_upd_req_t              upd_req;
  egb_upd_rsp_t              upd_rsp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q  <= ThresholdReset;
      mode_q <= ModeSampleAvg;
      step_q <= StepSizeReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgExploreThreshold: thr_q  <= cfg_wdata_i[DrawW-1:0];
        CfgUpdateMode:       mode_q <= cfg_wdata_i[0];
        CfgStepSize:         step_q <= cfg_wdata_i[StepW-1:0];
        default: ;
      endcase
    end
  end

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  assign link[0] = '0;

  for (genvar g = 0; g < ARMS; g++) begin : g_cell
    egb_cell #(
      .INDEX(g)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (cell_ctl),
      .link_i (link[g]),
      .link_o (link[g+1])
    );
  end

  always_comb begin
    cell_ctl.clear   = in_acc && (in_data_i.kind == KindFirst);
    cell_ctl.wr_en   = (state_q == S_UPD) && upd_rsp.done;
    cell_ctl.wr_arm  = last_arm_q;
    cell_ctl.wr_est  = upd_rsp.est;
    cell_ctl.wr_cnt  = upd_rsp.cnt;
    cell_ctl.sel_arm = last_arm_q;
  end

  always_comb begin
    upd_req.start  = (state_q == S_FETCH) && (scan_q == '0);
    upd_req.mode   = mode_q;
    upd_req.step   = step_q;
    upd_req.reward = reward_q;
    upd_req.est    = link[ARMS].fetch_est;
    upd_req.cnt    = link[ARMS].fetch_cnt;
  end

  egb_update u_update (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (upd_req),
    .rsp_o  (upd_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      scan_q      <= '0;
      last_arm_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            scan_q  <= ScanW'(ARMS);
            state_q <= (in_data_i.kind == KindFirst) ? S_DONE : S_FETCH;
          end
        end
        S_FETCH: begin
          if (scan_q == '0) state_q <= S_UPD;
          else scan_q <= scan_q - ScanW'(1);
        end
        S_UPD: begin
          if (upd_rsp.done) begin
            scan_q  <= ScanW'(ARMS);
            state_q <= (draw_q > thr_q) ? S_SCAN : S_DONE;
          end
        end
        S_SCAN: begin
          if (scan_q == '0) state_q <= S_DONE;
          else scan_q <= scan_q - ScanW'(1);
        end
        S_DONE: begin
          if (out_free) begin
            last_arm_q  <= res_arm_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          reward_q   <= in_data_i.reward;
          draw_q     <= in_data_i.random_draw;
          rarm_q     <= ModTab[in_data_i.random_arm];
          res_arm_q  <= ModTab[in_data_i.random_arm];
          res_expl_q <= 1'b1;
          res_est_q  <= '0;
        end
      end
      S_UPD: begin
        if (upd_rsp.done) begin
          res_est_q  <= upd_rsp.est;
          res_arm_q  <= rarm_q;
          res_expl_q <= 1'b1;
        end
      end
      S_SCAN: begin
        if (scan_q == '0) begin
          res_arm_q  <= link[ARMS].best_arm;
          res_expl_q <= 1'b0;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_data_q.chosen_arm       <= res_arm_q;
          out_data_q.explored         <= res_expl_q;
          out_data_q.updated_estimate <= res_est_q;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// File: tb/egb_checker.sv
`timescale 1ns / 1ps
module egb_checker #(
  parameter int ARMS = egb_pkg::DefaultArms
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic                         in_ready_i,
  input  egb_pkg::egb_in_t             in_data_i,
  input  logic                         out_valid_i,
  input  logic                         out_ready_i,
  input  egb_pkg::egb_out_t            out_data_i,
  input  logic                         cfg_we_i,
  input  logic [egb_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [egb_pkg::CfgDataW-1:0] cfg_wdata_i,
  output int unsigned                  fail_count_o,
  output int unsigned                  pending_o
);
  import egb_pkg::*;

  localparam longint EstHi = 2 ** (EstW - 1) - 1;
  localparam longint EstLo = -(2 ** (EstW - 1));

  logic [DrawW-1:0]       threshold_q;
  logic                   mode_q;
  logic [StepW-1:0]       alpha_q;
  logic signed [EstW-1:0] est_q [ARMS];
  logic [CntW-1:0]        pulls_q [ARMS];
  logic [ArmW-1:0]        prev_arm_q;

  egb_out_t    expected_q [$];
  int unsigned fails = 0;

  // Works out the answer to one request and advances the arm state
  function automatic egb_out_t predict_step(egb_in_t rq);
    egb_out_t    res;
    int unsigned prev;
    int unsigned best;
    longint      q;
    longint      diff;
    longint      upd;
    res = '0;
    if (rq.kind == KindFirst) begin
      for (int a = 0; a < ARMS; a++) begin
        est_q[a]   = '0;
        pulls_q[a] = '0;
      end
      res.chosen_arm = ArmW'(rq.random_arm % ARMS);
      res.explored   = 1'b1;
    end else begin
      prev = prev_arm_q % ARMS;
      q    = est_q[prev];
      diff = longint'($signed(rq.reward)) - q;
      if (mode_q == ModeSampleAvg) begin
        if (pulls_q[prev] != '1) pulls_q[prev] = pulls_q[prev] + 1'b1;
        upd = q + diff / longint'(pulls_q[prev]);
      end else begin
        upd = q + (diff * longint'(alpha_q)) / 65536;
      end
      if (upd > EstHi) upd = EstHi;
      if (upd < EstLo) upd = EstLo;
      est_q[prev] = EstW'(upd);
      res.updated_estimate = est_q[prev];
      if (rq.random_draw > threshold_q) begin
        // greedy: first arm holding the maximum wins
        best = 0;
        for (int a = 1; a < ARMS; a++) begin
          if (est_q[a] > est_q[best]) best = a;
        end
        res.chosen_arm = ArmW'(best);
        res.explored   = 1'b0;
      end else begin
        res.chosen_arm = ArmW'(rq.random_arm % ARMS);
        res.explored   = 1'b1;
      end
    end
    prev_arm_q = res.chosen_arm;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    egb_out_t want;
    if (!rst_ni) begin
      threshold_q = ThresholdReset;
      mode_q      = ModeSampleAvg;
      alpha_q     = StepSizeReset;
      prev_arm_q  = '0;
      for (int a = 0; a < ARMS; a++) begin
        est_q[a]   = '0;
        pulls_q[a] = '0;
      end
      expected_q.delete();
      pending_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_q.size() == 0) begin
          $error("unexpected result: chosen_arm %0d explored %0d updated_estimate %0d",
                 out_data_i.chosen_arm, out_data_i.explored,
                 $signed(out_data_i.updated_estimate));
          fails++;
        end else begin
          want = expected_q.pop_front();
          if (out_data_i.chosen_arm !== want.chosen_arm) begin
            $error("chosen_arm: expected %0d, got %0d", want.chosen_arm,
                   out_data_i.chosen_arm);
            fails++;
          end
          if (out_data_i.explored !== want.explored) begin
            $error("explored: expected %0d, got %0d", want.explored, out_data_i.explored);
            fails++;
          end
          if (out_data_i.updated_estimate !== want.updated_estimate) begin
            $error("updated_estimate: expected %0d, got %0d",
                   $signed(want.updated_estimate), $signed(out_data_i.updated_estimate));
            fails++;
          end
        end
      end
      if (in_valid_i && in_ready_i) expected_q.push_back(predict_step(in_data_i));
      // writes only arrive while idle, so ordering against requests is moot
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgExploreThreshold: threshold_q = cfg_wdata_i;
          CfgUpdateMode:       mode_q      = cfg_wdata_i[0];
          CfgStepSize:         alpha_q     = cfg_wdata_i;
          default: ;
        endcase
      end
      pending_o <= expected_q.size();
    end
    fail_count_o <= fails;
  end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import egb_pkg::*;

  localparam int Arms          = DefaultArms;
  localparam int HoldOffCycles = 400;
  localparam int SettleCycles  = 3 * Arms + 60;
  localparam int MaxGap        = 20;
  localparam longint CycleLimit = 2_000_000;
  localparam logic [CfgIdxW-1:0] CfgUnused = 2'd3;
  localparam logic KindLater = 1'b1;

  logic                clk;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  egb_in_t             in_data   = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  egb_out_t            out_data;
  logic                cfg_we    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx   = '0;
  logic [CfgDataW-1:0] cfg_wdata = '0;

  int unsigned fail_count;
  int unsigned pending;
  longint      cycles = 0;

  int unsigned      tx_idle_pct   = 12;
  int unsigned      rx_idle_pct   = 66;
  int unsigned      hold_off_reqs = 0;
  logic [DrawW-1:0] cur_threshold = ThresholdReset;

  epsilon_greedy_bandit_agent #(
    .ARMS(Arms)
  ) i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata)
  );

  egb_checker #(
    .ARMS(Arms)
  ) i_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_data_i  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Result side: random back-pressure, plus one long hold-off on request
  initial begin
    int unsigned served;
    served = 0;
    forever begin
      @(posedge clk);
      if (hold_off_reqs != served) begin
        served = hold_off_reqs;
        out_ready <= 1'b0;
        for (int n = 0; n < HoldOffCycles; n++) @(posedge clk);
      end else begin
        out_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  function automatic egb_in_t step_of(logic kind, logic [RewardW-1:0] reward,
                                      logic [DrawW-1:0] draw, logic [ArmW-1:0] arm);
    egb_in_t s;
    s.kind        = kind;
    s.reward      = reward;
    s.random_draw = draw;
    s.random_arm  = arm;
    return s;
  endfunction

  function automatic egb_in_t random_step();
    egb_in_t s;
    int      r;
    s.kind = ($urandom_range(99) < 3) ? KindFirst : KindLater;
    case ($urandom_range(7))
      0:       s.reward = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
      1, 2, 3: begin
        r = int'($urandom_range(8192)) - 4096;
        s.reward = RewardW'(r);
      end
      default: s.reward = RewardW'($urandom);
    endcase
    // draws close to the threshold exercise the explore/exploit boundary
    case ($urandom_range(9))
      0:       s.random_draw = cur_threshold;
      1:       s.random_draw = cur_threshold + 1'b1;
      2:       s.random_draw = $urandom_range(1) ? '1 : '0;
      default: s.random_draw = DrawW'($urandom);
    endcase
    s.random_arm = ArmW'($urandom_range(ArmCodes - 1));
    return s;
  endfunction

  task automatic push_step(egb_in_t s);
    int gap;
    in_valid <= 1'b1;
    in_data  <= s;
    do @(posedge clk); while (!in_ready);
    gap = 0;
    while (gap < MaxGap && $urandom_range(99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic set_registers(logic [DrawW-1:0] th, logic mode, logic [StepW-1:0] alpha);
    logic [CfgDataW-1:0] mode_word;
    mode_word    = CfgDataW'($urandom);
    mode_word[0] = mode;
    drain_results();
    write_reg(CfgExploreThreshold, th);
    write_reg(CfgUpdateMode, mode_word);
    write_reg(CfgStepSize, alpha);
    // unused index: must leave everything alone
    write_reg(CfgUnused, CfgDataW'($urandom));
    cfg_we <= 1'b0;
    cur_threshold = th;
  endtask

  task automatic run_phase(logic [DrawW-1:0] th, logic mode, logic [StepW-1:0] alpha,
                           int n, int unsigned tx_pct, int unsigned rx_pct, bit hold);
    set_registers(th, mode, alpha);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    for (int k = 0; k < n; k++) begin
      if (hold && k == n / 3) hold_off_reqs++;
      if (k == n / 2) drain_results();
      push_step(random_step());
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset register values; later steps before any first step
    push_step(step_of(KindLater, 16'h7FFF, 16'd0, 6'd63));
    push_step(step_of(KindLater, 16'h8000, 16'hFFFF, 6'd0));
    push_step(step_of(KindLater, 16'h0000, ThresholdReset, 6'd10));
    push_step(step_of(KindLater, 16'h0000, ThresholdReset + 1'b1, 6'd62));
    push_step(step_of(KindFirst, 16'h8000, 16'hFFFF, 6'd9));
    // all estimates level: greedy must take arm 0
    push_step(step_of(KindLater, 16'h0000, 16'hFFFF, 6'd5));
    push_step(step_of(KindLater, 16'h7FFF, 16'hFFFF, 6'd0));
    push_step(step_of(KindLater, 16'h7FFF, 16'hFFFF, 6'd0));
    push_step(step_of(KindLater, 16'h8000, 16'd0, 6'd1));
    push_step(step_of(KindLater, 16'h1000, 16'hFFFF, 6'd7));
    push_step(step_of(KindLater, 16'hFFFF, 16'hFFFF, 6'd33));
    push_step(step_of(KindLater, 16'h5555, 16'hAAAA, 6'h2A));
    push_step(step_of(KindLater, 16'hAAAA, 16'h5555, 6'h15));

    set_registers(16'd0, ModeConstStep, 16'hFFFF);
    push_step(step_of(KindLater, 16'h7FFF, 16'd1, 6'd20));
    push_step(step_of(KindLater, 16'h8000, 16'd0, 6'd63));
    push_step(step_of(KindLater, 16'h8000, 16'hFFFF, 6'd4));

    // zero step size leaves estimates; top threshold never exploits
    set_registers(16'hFFFF, ModeConstStep, 16'd0);
    push_step(step_of(KindLater, 16'h7FFF, 16'hFFFF, 6'd11));
    push_step(step_of(KindLater, 16'h8000, 16'd40000, 6'd59));

    run_phase(ThresholdReset, ModeSampleAvg, StepSizeReset, 450, 12, 66, 1'b0);
    run_phase(16'hFFFF, ModeConstStep, 16'd32768, 250, 12, 66, 1'b0);
    run_phase(16'd0, ModeConstStep, 16'hFFFF, 400, 66, 12, 1'b0);
    run_phase(DrawW'($urandom_range(1, 65534)), ModeSampleAvg,
              StepW'($urandom_range(1, 65534)), 400, 66, 12, 1'b0);
    run_phase(16'd32768, ModeConstStep, 16'd1, 300, 0, 0, 1'b1);
    run_phase(ThresholdReset, ModeSampleAvg, 16'd0, 250, 0, 0, 1'b1);

    drain_results();
    repeat (SettleCycles) @(posedge clk);
    if (pending != 0) $error("%0d results never arrived", pending);
    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
